[hdl/positional_ordered_list_macros.svh]
// Assertion macros for the positional ordered list RTL.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define POL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_ordered_list: check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define POL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_ordered_list: check failed");

`endif

[hdl/pol_pkg.sv]
// Types, codes and constants of the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

  localparam int DATA_W       = 32;
  localparam int FUNC_W       = 3;
  localparam int POS_W        = 7;
  localparam int CNT_OUT_W    = 7;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

  // Operation codes; code 7 is unused and reported as bad
  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_PREPEND      = 3'd1,
    OP_POP_FRONT    = 3'd2,
    OP_POP_BACK     = 3'd3,
    OP_READ         = 3'd4,
    OP_INSERT_AFTER = 3'd5,
    OP_REMOVE_AT    = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // How the cell row moves this cycle
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_OPEN,
    SH_CLOSE
  } shift_kind_t;

  // Where the result value comes from
  typedef enum logic [1:0] {
    VS_ZERO,
    VS_NEG_ONE,
    VS_ENTRY
  } val_src_t;

  // Command broadcast to every cell
  typedef struct packed {
    shift_kind_t       kind;
    logic [DATA_W-1:0] ins_value;
  } pol_ctrl_t;

  // Result selection from the decoder
  typedef struct packed {
    val_src_t src;
    status_t  status;
  } pol_res_t;

endpackage

[hdl/pol_cell.sv]
// One storage cell of the list row: holds an entry, shifts with its neighbors.
`timescale 1ns / 1ps

module pol_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic                         clk,
  input  logic                         en,
  input  pol_pkg::pol_ctrl_t           ctrl,
  input  logic [IW-1:0]                idx,
  input  logic [pol_pkg::DATA_W-1:0]   left_val,
  input  logic [pol_pkg::DATA_W-1:0]   right_val,
  output logic [pol_pkg::DATA_W-1:0]   val,
  output logic [pol_pkg::DATA_W-1:0]   rd_val
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [pol_pkg::DATA_W-1:0] val_r;
  logic [pol_pkg::DATA_W-1:0] val_nxt;

  // Next entry: open a gap at idx, or close the gap at idx
  always_comb begin
    val_nxt = val_r;
    case (ctrl.kind)
      pol_pkg::SH_OPEN: begin
        if (MY_IDX == idx) begin
          val_nxt = ctrl.ins_value;
        end else if (MY_IDX > idx) begin
          val_nxt = left_val;
        end
      end
      pol_pkg::SH_CLOSE: begin
        if (MY_IDX >= idx) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  // Entry register, payload only
  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

  assign val    = val_r;
  // Drive the read bus only when selected
  assign rd_val = (MY_IDX == idx) ? val_r : '0;

endmodule

[hdl/pol_ctrl.sv]
// Operation decoder: checks count and position, picks the shift and the result.
`timescale 1ns / 1ps

module pol_ctrl #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int IW       = $clog2(CAPACITY)
) (
  input  logic [pol_pkg::FUNC_W-1:0]  func,
  input  logic [pol_pkg::DATA_W-1:0]  data_value,
  input  logic [pol_pkg::POS_W-1:0]   position,
  input  logic [CW-1:0]               count,
  output pol_pkg::pol_ctrl_t          ctrl,
  output logic [IW-1:0]               idx,
  output pol_pkg::pol_res_t           res,
  output logic [CW-1:0]               count_nxt
);

  localparam int CMPW = CW + pol_pkg::POS_W;

  logic            full;
  logic            empty;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] pos_m1;
  logic            pos_gt_cnt;
  logic            pos_bad;

  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign pos_x      = CMPW'(position);
  assign cnt_x      = CMPW'(count);
  assign pos_m1     = pos_x - CMPW'(1);
  assign pos_gt_cnt = (pos_x > cnt_x);
  // read and remove need 1 <= position <= count
  assign pos_bad    = (pos_x == '0) || pos_gt_cnt;

  always_comb begin
    ctrl.kind      = pol_pkg::SH_HOLD;
    ctrl.ins_value = data_value;
    idx            = '0;
    res.src        = pol_pkg::VS_ZERO;
    res.status     = pol_pkg::ST_OK;
    count_nxt      = count;
    case (pol_pkg::func_t'(func))
      pol_pkg::OP_APPEND: begin
        if (full) begin
          res.status = pol_pkg::ST_FULL;
        end else begin
          ctrl.kind = pol_pkg::SH_OPEN;
          idx       = IW'(count);
          count_nxt = count + CW'(1);
        end
      end
      pol_pkg::OP_PREPEND: begin
        if (full) begin
          res.status = pol_pkg::ST_FULL;
        end else begin
          ctrl.kind = pol_pkg::SH_OPEN;
          count_nxt = count + CW'(1);
        end
      end
      pol_pkg::OP_POP_FRONT: begin
        if (empty) begin
          res.status = pol_pkg::ST_BAD;
          res.src    = pol_pkg::VS_NEG_ONE;
        end else begin
          ctrl.kind = pol_pkg::SH_CLOSE;
          res.src   = pol_pkg::VS_ENTRY;
          count_nxt = count - CW'(1);
        end
      end
      pol_pkg::OP_POP_BACK: begin
        if (empty) begin
          res.status = pol_pkg::ST_BAD;
          res.src    = pol_pkg::VS_NEG_ONE;
        end else begin
          ctrl.kind = pol_pkg::SH_CLOSE;
          idx       = IW'(count - CW'(1));
          res.src   = pol_pkg::VS_ENTRY;
          count_nxt = count - CW'(1);
        end
      end
      pol_pkg::OP_READ: begin
        idx = IW'(pos_m1);
        if (pos_bad) begin
          res.status = pol_pkg::ST_BAD;
          res.src    = pol_pkg::VS_NEG_ONE;
        end else begin
          res.src = pol_pkg::VS_ENTRY;
        end
      end
      pol_pkg::OP_INSERT_AFTER: begin
        // full is checked before the position
        if (full) begin
          res.status = pol_pkg::ST_FULL;
        end else if (pos_gt_cnt) begin
          res.status = pol_pkg::ST_BAD;
          res.src    = pol_pkg::VS_NEG_ONE;
        end else begin
          ctrl.kind = pol_pkg::SH_OPEN;
          idx       = IW'(pos_x);
          count_nxt = count + CW'(1);
        end
      end
      pol_pkg::OP_REMOVE_AT: begin
        idx = IW'(pos_m1);
        if (pos_bad) begin
          res.status = pol_pkg::ST_BAD;
          res.src    = pol_pkg::VS_NEG_ONE;
        end else begin
          ctrl.kind = pol_pkg::SH_CLOSE;
          res.src   = pol_pkg::VS_ENTRY;
          count_nxt = count - CW'(1);
        end
      end
      default: begin
        res.status = pol_pkg::ST_BAD;
        res.src    = pol_pkg::VS_NEG_ONE;
      end
    endcase
  end

endmodule

[hdl/positional_ordered_list.sv]
// Top level of the positional ordered list: decoder, cell row and result register.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: func; tdata: data_value, position
//  out_    | out | out_tvalid/tready   | tdata: read_value, entry_count, status
//
// The whole cell row shifts in the cycle the input transfer is accepted, and the
// result is registered for the next cycle.
// Sustained rate is one item per cycle while the result side keeps taking.
// A stalled result holds the input side (in_tready low) until it is taken.
// Synchronous active-low reset empties the list; entry cells are not cleared.
`timescale 1ns / 1ps

`include "positional_ordered_list_macros.svh"

module positional_ordered_list #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_value, [38:32] position, [39] zero
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] read_value, [38:32] entry_count,
                                  // [40:39] status, [47:41] zero
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int DW = pol_pkg::DATA_W;

  logic                       accept;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  pol_pkg::pol_ctrl_t         ctrl;
  pol_pkg::pol_res_t          res;
  logic [IW-1:0]              idx;
  logic [DW-1:0]              cell_val [CAPACITY];
  logic [DW-1:0]              cell_rd  [CAPACITY];
  logic [DW-1:0]              rd_value;
  logic [DW-1:0]              res_value;
  logic                       out_valid_r;
  logic [DW-1:0]              out_value_r;
  pol_pkg::status_t           out_status_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Decode the operation against the current count
  pol_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .IW       (IW)
  ) u_ctrl (
    .func       (in_tuser),
    .data_value (in_tdata[31:0]),
    .position   (in_tdata[38:32]),
    .count      (count_r),
    .ctrl       (ctrl),
    .idx        (idx),
    .res        (res),
    .count_nxt  (count_nxt)
  );

  // Row of cells; each trades entries with its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_val;
    logic [DW-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end
    pol_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .en        (accept),
      .ctrl      (ctrl),
      .idx       (idx),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i]),
      .rd_val    (cell_rd[i])
    );
  end

  // Read bus: only the selected cell drives nonzero
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | cell_rd[i];
    end
  end

  always_comb begin
    case (res.src)
      pol_pkg::VS_ENTRY:   res_value = rd_value;
      pol_pkg::VS_NEG_ONE: res_value = pol_pkg::NEG_ONE;
      default:             res_value = '0;
    endcase
  end

  // Count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= res_value;
      out_status_r <= res.status;
    end
  end

  // count_r always belongs to the result on display
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_status_r, pol_pkg::CNT_OUT_W'(count_r), out_value_r};

  // Checks
  `POL_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CW'(CAPACITY))
  `POL_ASSERT_NEXT(a_stall_holds_count, out_valid_r && !out_tready, $stable(count_r))
  `POL_ASSERT_NOW(a_full_at_cap, out_valid_r && out_status_r == pol_pkg::ST_FULL, count_r == CW'(CAPACITY))
  `POL_ASSERT_NOW(a_bad_neg_one, out_valid_r && out_status_r == pol_pkg::ST_BAD, out_value_r == pol_pkg::NEG_ONE)
  `POL_ASSERT_NEXT(a_ok_add_grows, accept && res.status == pol_pkg::ST_OK && ctrl.kind == pol_pkg::SH_OPEN, count_r == $past(count_r) + CW'(1))

endmodule

[bench/positional_ordered_list_tb.sv]
// Self-checking testbench for the positional ordered list: directed table, then random traffic.
`timescale 1ns / 1ps

module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int CAPACITY        = CAPACITY_DEF;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int RANDOM_PER_PHASE = 534;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_PRINTED     = 40;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
  localparam logic [DATA_W-1:0] DATA_MAX    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] DATA_MIN    = 32'h8000_0000;

  // One result: what the list hands back for an operation
  typedef struct packed {
    logic [DATA_W-1:0]    value;
    logic [CNT_OUT_W-1:0] count;
    status_t              status;
  } list_result_t;

  // Directed row: operation, repeat count, and an optional hand-typed result
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [6:0]        reps;
    logic              typed;
    list_result_t      res;
  } plan_row_t;

  localparam list_result_t NO_RES = '{'0, '0, ST_OK};

  localparam int PLAN_LEN = 29;
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    // empty list: pops, reads, removes, inserts past the end and the unused code are rejected
    '{OP_POP_FRONT,    32'd0,         7'd0,  7'd1,  1'b1, '{NEG_ONE, 7'd0, ST_BAD}},
    '{OP_POP_BACK,     32'd0,         7'd0,  7'd1,  1'b1, '{NEG_ONE, 7'd0, ST_BAD}},
    '{OP_READ,         32'd0,         7'd0,  7'd1,  1'b1, '{NEG_ONE, 7'd0, ST_BAD}},
    '{OP_REMOVE_AT,    32'd0,         7'd1,  7'd1,  1'b1, '{NEG_ONE, 7'd0, ST_BAD}},
    '{OP_INSERT_AFTER, 32'd1,         7'd1,  7'd1,  1'b1, '{NEG_ONE, 7'd0, ST_BAD}},
    '{FUNC_UNUSED,     32'd0,         7'd0,  7'd1,  1'b1, '{NEG_ONE, 7'd0, ST_BAD}},
    // build a short list with the data extremes, then read, remove and pop
    '{OP_APPEND,       DATA_MAX,      7'd0,  7'd1,  1'b1, '{32'd0, 7'd1, ST_OK}},
    '{OP_PREPEND,      DATA_MIN,      7'd0,  7'd1,  1'b1, '{32'd0, 7'd2, ST_OK}},
    '{OP_INSERT_AFTER, NEG_ONE,       7'd0,  7'd1,  1'b1, '{32'd0, 7'd3, ST_OK}},
    '{OP_INSERT_AFTER, 32'd0,         7'd3,  7'd1,  1'b1, '{32'd0, 7'd4, ST_OK}},
    '{OP_INSERT_AFTER, 32'h5555_5555, 7'd2,  7'd1,  1'b1, '{32'd0, 7'd5, ST_OK}},
    '{OP_READ,         32'd0,         7'd1,  7'd1,  1'b0, NO_RES},
    '{OP_READ,         32'd0,         7'd5,  7'd1,  1'b0, NO_RES},
    '{OP_READ,         32'd0,         7'd6,  7'd1,  1'b1, '{NEG_ONE, 7'd5, ST_BAD}},
    '{OP_READ,         32'd0,         7'd0,  7'd1,  1'b1, '{NEG_ONE, 7'd5, ST_BAD}},
    '{OP_REMOVE_AT,    32'd0,         7'd3,  7'd1,  1'b0, NO_RES},
    '{OP_INSERT_AFTER, 32'hAAAA_AAAA, 7'd5,  7'd1,  1'b1, '{NEG_ONE, 7'd4, ST_BAD}},
    '{OP_POP_FRONT,    32'd0,         7'd0,  7'd1,  1'b0, NO_RES},
    '{OP_POP_BACK,     32'd0,         7'd0,  7'd1,  1'b0, NO_RES},
    '{FUNC_UNUSED,     NEG_ONE,       7'd64, 7'd1,  1'b1, '{NEG_ONE, 7'd2, ST_BAD}},
    // fill to capacity, then every add is refused before the position is looked at; then read and remove at the edges
    '{OP_APPEND,       32'h0F0F_0F00, 7'd0,  7'd62, 1'b0, NO_RES},
    '{OP_APPEND,       32'd7,         7'd0,  7'd1,  1'b1, '{32'd0, 7'd64, ST_FULL}},
    '{OP_PREPEND,      32'd7,         7'd0,  7'd1,  1'b1, '{32'd0, 7'd64, ST_FULL}},
    '{OP_INSERT_AFTER, 32'd7,         7'd0,  7'd1,  1'b1, '{32'd0, 7'd64, ST_FULL}},
    '{OP_INSERT_AFTER, 32'd7,         7'd64, 7'd1,  1'b1, '{32'd0, 7'd64, ST_FULL}},
    '{OP_READ,         32'd0,         7'd64, 7'd1,  1'b0, NO_RES},
    '{OP_REMOVE_AT,    32'd0,         7'd64, 7'd1,  1'b0, NO_RES},
    '{OP_REMOVE_AT,    32'd0,         7'd1,  7'd1,  1'b0, NO_RES},
    '{OP_REMOVE_AT,    32'd0,         7'd63, 7'd1,  1'b1, '{NEG_ONE, 7'd62, ST_BAD}}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [31:0] data_value, [38:32] position, [39] zero
  logic [2:0]  in_tuser   = '0;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [31:0] read_value, [38:32] entry_count,
                                  // [40:39] status, [47:41] zero

  logic [DATA_W-1:0] shadow_list [$];   // predicted list contents, front first
  list_result_t      due_results [$];   // results still owed by the block
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;
  int                tx_idle_pct    = 18;
  int                rx_idle_pct    = 78;
  int                rx_hold_left   = 0;
  int                stall_req_seq  = 0;
  int                stall_ack_seq  = 0;
  bit                growing        = 1'b1;

  positional_ordered_list #(.CAPACITY(CAPACITY)) dut (
    clk, rst_n,
    in_tvalid, in_tready, in_tdata, in_tuser,
    out_tvalid, out_tready, out_tdata
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Apply one operation to the shadow list and return what the block must answer
  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] f,
                                                 input logic [DATA_W-1:0] d,
                                                 input logic [POS_W-1:0]  p);
    list_result_t r;
    int           n;
    bit           full;
    n       = shadow_list.size();
    full    = (n >= CAPACITY);
    r.value  = '0;
    r.status = ST_OK;
    case (f)
      OP_APPEND: begin
        if (full) r.status = ST_FULL;
        else shadow_list.push_back(d);
      end
      OP_PREPEND: begin
        if (full) r.status = ST_FULL;
        else shadow_list.push_front(d);
      end
      OP_POP_FRONT: begin
        if (n == 0) r.status = ST_BAD;
        else r.value = shadow_list.pop_front();
      end
      OP_POP_BACK: begin
        if (n == 0) r.status = ST_BAD;
        else r.value = shadow_list.pop_back();
      end
      OP_READ: begin
        if (p == 0 || p > n) r.status = ST_BAD;
        else r.value = shadow_list[p - 1];
      end
      OP_INSERT_AFTER: begin
        if (full) r.status = ST_FULL;
        else if (p > n) r.status = ST_BAD;
        else shadow_list.insert(p, d);
      end
      OP_REMOVE_AT: begin
        if (p == 0 || p > n) begin
          r.status = ST_BAD;
        end else begin
          r.value = shadow_list[p - 1];
          shadow_list.delete(p - 1);
        end
      end
      default: r.status = ST_BAD;
    endcase
    if (r.status == ST_BAD) r.value = NEG_ONE;
    r.count = CNT_OUT_W'(shadow_list.size());
    return r;
  endfunction

  // Offer one item on the input channel and return once it is transferred
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] d,
                           input logic [POS_W-1:0] p, input bit typed,
                           input list_result_t typed_res);
    list_result_t predicted;
    predicted = apply_list_op(f, d, p);
    due_results.push_back(typed ? typed_res : predicted);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {1'b0, p, d};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the input idle until the block has answered everything
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return NEG_ONE;
      2:       return DATA_MAX;
      3:       return DATA_MIN;
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid positions, with the edges and some out-of-range ones
  function automatic logic [POS_W-1:0] pick_position(input int n);
    case ($urandom_range(9))
      0:       return '0;
      1:       return POS_W'((n < CAPACITY) ? n + 1 : CAPACITY);
      2:       return POS_W'(n);
      3:       return POS_W'($urandom_range(CAPACITY));
      default: return (n == 0) ? '0 : POS_W'($urandom_range(n, 1));
    endcase
  endfunction

  // Random operation; the mix swings between filling and draining the list
  task automatic send_random_op();
    int                n;
    int                r;
    logic [FUNC_W-1:0] f;
    n = shadow_list.size();
    if (n >= CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
    if (n == 0 && $urandom_range(3) == 0) growing = 1'b1;
    r = $urandom_range(99);
    if (r < 2)
      f = FUNC_UNUSED;
    else if (r < 12)
      f = OP_READ;
    else if (growing)
      f = (r < 40) ? OP_APPEND : (r < 58) ? OP_PREPEND : (r < 80) ? OP_INSERT_AFTER :
          (r < 87) ? OP_POP_FRONT : (r < 93) ? OP_POP_BACK : OP_REMOVE_AT;
    else
      f = (r < 19) ? OP_APPEND : (r < 24) ? OP_PREPEND : (r < 30) ? OP_INSERT_AFTER :
          (r < 52) ? OP_POP_FRONT : (r < 74) ? OP_POP_BACK : OP_REMOVE_AT;
    send_item(f, pick_value(), pick_position(n), 1'b0, NO_RES);
  endtask

  // Result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      out_tready   <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (stall_req_seq != stall_ack_seq) begin
      out_tready    <= 1'b0;
      rx_hold_left  <= RX_HOLD_CYCLES;
      stall_ack_seq <= stall_req_seq;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check each result transfer against the oldest owed result
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing owed, tdata %h", out_tdata));
      end else begin
        want = due_results.pop_front();
        if (out_tdata[31:0] !== want.value)
          flag_mismatch($sformatf("read_value %h, want %h", out_tdata[31:0], want.value));
        if (out_tdata[38:32] !== want.count)
          flag_mismatch($sformatf("entry_count %0d, want %0d", out_tdata[38:32], want.count));
        if (out_tdata[40:39] !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_tdata[40:39], want.status));
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL positional_ordered_list");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (PLAN[i]) begin
      for (int k = 0; k < PLAN[i].reps; k++)
        send_item(PLAN[i].func, PLAN[i].data + k, PLAN[i].pos, PLAN[i].typed, PLAN[i].res);
    end
    drain_results();

    // random phases: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 78 : 0;
      rx_idle_pct <= (ph == 0) ? 78 : (ph == 1) ? 18 : 0;
      // long receiver hold-off while the sender keeps offering
      if (ph != 1) stall_req_seq <= stall_req_seq + 1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_op();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("PASS positional_ordered_list");
    else $display("FAIL positional_ordered_list");
    $finish;
  end

endmodule
